[design/hgce_pkg.sv]
// Package: shared types and constants for the HTTP GET command extractor.
`timescale 1ns / 1ps
`default_nettype none
package hgce_pkg;

    localparam int PREFIX_MAX  = 8;
    localparam int JOB_CNT_W   = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [2:0] ST_CMD        = 3'd0;
    localparam logic [2:0] ST_INDEX      = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_FAIL_HUNT  = 3'd3;
    localparam logic [2:0] ST_FAIL_SLASH = 3'd4;
    localparam logic [2:0] ST_FAIL_PATH  = 3'd5;
    localparam logic [2:0] ST_TOO_LONG   = 3'd6;
    localparam logic [2:0] ST_PREFIX     = 3'd7;

    localparam logic REG_PREFIX_LEN   = 1'b0;
    localparam logic REG_PREFIX_CHARS = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SLASH,
        PH_PATH
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DATA
    } back_state_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [3:0]           first;
        logic [JOB_CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } queue_ctl_t;

endpackage
`default_nettype wire

[design/hgce_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module hgce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/hgce_fifo.sv]
// Short job queue between the parser front and the result back end.
`timescale 1ns / 1ps
`default_nettype none
module hgce_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

[design/hgce_front.sv]
// Parser front: configuration registers, GET hunt, path capture and job issue.
`timescale 1ns / 1ps
`default_nettype none
module hgce_front
    import hgce_pkg::*;
#(
    parameter int PATH_LEN_MAX = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [63:0]                     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire logic [7:0]                      data_byte,
    output logic                                 push,
    output job_t                                 job,
    input  wire logic                            queue_full,
    input  wire logic                            replay_done,
    output logic                                 ram_we,
    output logic [$clog2(PATH_LEN_MAX)-1:0]      ram_waddr,
    output logic [7:0]                           ram_wdata,
    output logic                                 replay_pend
);

    localparam int AW = $clog2(PATH_LEN_MAX);
    localparam int CW = $clog2(PATH_LEN_MAX + 1);

    logic [3:0]           prefix_len_reg;
    logic [63:0]          prefix_chars_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [15:0]          recent_reg;
    logic [15:0]          recent_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 bad_reg;
    logic                 bad_next;
    logic                 pend_reg;
    logic                 pend_next;

    logic                 accept;
    logic                 is_sp;
    logic                 is_slash;
    logic                 is_crlf;
    logic                 get_hit;
    logic [CW-1:0]        count_inc;
    logic                 at_full;
    logic [3:0]           plen_eff;
    logic [JOB_CNT_W-1:0] cnt_ext;
    logic [JOB_CNT_W-1:0] plen_ext;
    logic [7:0]           pfx_byte;

    assign cfg_ready   = 1'b1;
    assign in_stall    = queue_full || ((phase_reg == PH_PATH) && pend_reg);
    assign accept      = in_valid && !in_stall;
    assign replay_pend = pend_reg;

    assign is_sp     = (data_byte == CH_SPACE);
    assign is_slash  = (data_byte == CH_SLASH);
    assign is_crlf   = (data_byte == CH_CR) || (data_byte == CH_LF);
    assign get_hit   = (recent_reg == {CH_G, CH_E}) && (data_byte == CH_T);
    assign count_inc = count_reg + CW'(1);
    assign at_full   = (count_inc == CW'(PATH_LEN_MAX));
    assign plen_eff  = (prefix_len_reg > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : prefix_len_reg;
    assign cnt_ext   = JOB_CNT_W'(count_reg);
    assign plen_ext  = JOB_CNT_W'(plen_eff);
    assign pfx_byte  = prefix_chars_reg[cnt_ext[2:0] * 8 +: 8];

    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (mode)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SLASH:
                    begin
                        if (is_slash)
                        begin
                            phase_next = PH_PATH;
                        end
                        else if (!is_sp)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_PATH:
                    begin
                        if (is_crlf || is_sp || at_full)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        phase_next = get_hit ? PH_SLASH : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        recent_next = recent_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        push        = 1'b0;
        job         = '0;
        ram_we      = 1'b0;
        if (accept)
        begin
            if (mode)
            begin
                push = 1'b1;
                unique case (phase_reg)
                    PH_SLASH: job.status = ST_FAIL_SLASH;
                    PH_PATH:  job.status = ST_FAIL_PATH;
                    default:  job.status = ST_FAIL_HUNT;
                endcase
                recent_next = '0;
                count_next  = '0;
                bad_next    = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SLASH:
                    begin
                        if (is_slash || !is_sp)
                        begin
                            recent_next = '0;
                            count_next  = '0;
                            bad_next    = 1'b0;
                        end
                    end
                    PH_PATH:
                    begin
                        if (is_crlf)
                        begin
                            recent_next = '0;
                            count_next  = '0;
                            bad_next    = 1'b0;
                        end
                        else if (!is_sp)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_inc;
                            if ((cnt_ext < plen_ext) && (data_byte != pfx_byte))
                            begin
                                bad_next = 1'b1;
                            end
                            if (at_full)
                            begin
                                push        = 1'b1;
                                job.status  = ST_TOO_LONG;
                                recent_next = '0;
                                count_next  = '0;
                                bad_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            push        = 1'b1;
                            recent_next = '0;
                            count_next  = '0;
                            bad_next    = 1'b0;
                            if (count_reg == '0)
                            begin
                                job.status = ST_INDEX;
                            end
                            else if ((cnt_ext < plen_ext) || bad_reg)
                            begin
                                job.status = ST_PREFIX;
                            end
                            else if (cnt_ext == plen_ext)
                            begin
                                job.status = ST_EMPTY;
                            end
                            else
                            begin
                                job.status = ST_CMD;
                                job.first  = plen_eff;
                                job.count  = cnt_ext;
                            end
                        end
                    end
                    default:
                    begin
                        recent_next = get_hit ? 16'h0000 : {recent_reg[7:0], data_byte};
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (replay_done)
        begin
            pend_next = 1'b0;
        end
        if (push && (job.status == ST_CMD))
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_len_reg   <= '0;
            prefix_chars_reg <= '0;
            phase_reg        <= PH_HUNT;
            recent_reg       <= '0;
            count_reg        <= '0;
            bad_reg          <= 1'b0;
            pend_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PREFIX_LEN:   prefix_len_reg   <= cfg_data[3:0];
                    REG_PREFIX_CHARS: prefix_chars_reg <= cfg_data;
                    default:          prefix_len_reg   <= prefix_len_reg;
                endcase
            end
            phase_reg  <= phase_next;
            recent_reg <= recent_next;
            count_reg  <= count_next;
            bad_reg    <= bad_next;
            pend_reg   <= pend_next;
        end
    end

endmodule
`default_nettype wire

[design/hgce_back.sv]
// Result back end: single status words and command replay from the path store.
`timescale 1ns / 1ps
`default_nettype none
module hgce_back
    import hgce_pkg::*;
#(
    parameter int PATH_LEN_MAX = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            queue_empty,
    output logic                                 pop,
    input  wire job_t                            job,
    output logic                                 ram_re,
    output logic [$clog2(PATH_LEN_MAX)-1:0]      ram_raddr,
    input  wire logic [7:0]                      ram_rdata,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           status,
    output logic [7:0]                           cmd_char,
    output logic                                 last,
    output logic                                 replay_done
);

    localparam int AW = $clog2(PATH_LEN_MAX);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [JOB_CNT_W-1:0] addr_reg;
    logic [JOB_CNT_W-1:0] addr_next;
    logic [JOB_CNT_W-1:0] end_reg;
    logic [JOB_CNT_W-1:0] end_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [2:0]           status_reg;
    logic [7:0]           char_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 is_last;
    logic                 load_single;
    logic                 load_char;
    logic                 start_replay;

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = ((addr_reg + JOB_CNT_W'(1)) == end_reg);
    assign ram_raddr = addr_reg[AW-1:0];

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign cmd_char  = char_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty && out_free && (job.status == ST_CMD))
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_DATA;
            end
            BK_DATA:
            begin
                if (out_free)
                begin
                    state_next = is_last ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        ram_re       = 1'b0;
        load_single  = 1'b0;
        load_char    = 1'b0;
        start_replay = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty && out_free)
                begin
                    pop          = 1'b1;
                    start_replay = (job.status == ST_CMD);
                    load_single  = (job.status != ST_CMD);
                end
            end
            BK_READ:
            begin
                ram_re = 1'b1;
            end
            BK_DATA:
            begin
                load_char = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        replay_done = load_char && is_last;
    end

    always_comb
    begin
        addr_next      = addr_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (start_replay)
        begin
            addr_next = JOB_CNT_W'(job.first);
            end_next  = job.count;
        end
        else if (load_char)
        begin
            addr_next = addr_reg + JOB_CNT_W'(1);
        end
        if (load_single || load_char)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            addr_reg      <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_single)
        begin
            status_reg <= job.status;
            char_reg   <= 8'h00;
            last_reg   <= 1'b1;
        end
        else if (load_char)
        begin
            status_reg <= ST_CMD;
            char_reg   <= ram_rdata;
            last_reg   <= is_last;
        end
    end

endmodule
`default_nettype wire

[design/http_get_command_extractor.sv]
// Top level: HTTP GET command extractor.
// Takes one request byte per cycle while in_stall is low. The front parser hunts for GET,
// skips spaces to the slash and writes path bytes into a path store RAM; each outcome goes
// as a job into a four-entry queue. The back end turns a job into one status word, or
// replays the path bytes after the prefix via a RAM read, then the output register. While a
// replay is still queued or running, the front stalls once it collects a new path; hunting
// and slash seeking go on at one byte per cycle unless the job queue is full. The output
// register holds a word under out_stall. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module http_get_command_extractor
    import hgce_pkg::*;
#(
    parameter int PATH_LEN_MAX = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       cmd_char,
    output logic             last
);

    localparam int AW = $clog2(PATH_LEN_MAX);

    queue_ctl_t    qctl;
    job_t          job_in;
    job_t          job_out;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          replay_done;
    logic          replay_pend;

    hgce_front #(
        .PATH_LEN_MAX (PATH_LEN_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .push        (qctl.push),
        .job         (job_in),
        .queue_full  (qctl.full),
        .replay_done (replay_done),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .replay_pend (replay_pend)
    );

    hgce_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (qctl.push),
        .wdata (job_in),
        .pop   (qctl.pop),
        .rdata (job_out),
        .full  (qctl.full),
        .empty (qctl.empty)
    );

    hgce_ram #(
        .WIDTH (8),
        .DEPTH (PATH_LEN_MAX)
    ) u_path_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hgce_back #(
        .PATH_LEN_MAX (PATH_LEN_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (qctl.empty),
        .pop         (qctl.pop),
        .job         (job_out),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cmd_char    (cmd_char),
        .last        (last),
        .replay_done (replay_done)
    );

    a_no_path_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !replay_pend)
        else $error("path store written during replay");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> !qctl.full)
        else $error("job queue overflow");

    a_status_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_CMD)) |-> last)
        else $error("status word without last");

    a_replay_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        replay_done |-> replay_pend)
        else $error("replay finished with none pending");

endmodule
`default_nettype wire
